>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with reset disable, removable with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_IMPL(label, clk, rst_n, cond, conseq)
`endif
`endif

>>> hdl/wsfe_pkg.sv
// ---------------------------------------------------------------------------
// wsfe_pkg
// Shared types, constants and header byte functions of the frame encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package wsfe_pkg;

  // Default depth of the job queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0]  OPCODE_BYTE  = 8'h81;
  localparam logic [7:0]  LEN16_MARK   = 8'hFE;
  localparam logic [7:0]  LEN64_MARK   = 8'hFF;
  localparam logic [31:0] SHORT_LIMIT  = 32'd125;
  localparam logic [31:0] MEDIUM_LIMIT = 32'd65535;

  typedef enum logic [1:0] {
    JOB_HEADER,
    JOB_DATA,
    JOB_ERROR
  } job_kind_e;

  typedef enum logic [1:0] {
    LEN_SHORT,
    LEN_MEDIUM,
    LEN_LONG
  } len_fmt_e;

  // One unit of work handed from front to back
  typedef struct packed {
    job_kind_e   kind;
    len_fmt_e    fmt;
    logic [31:0] len;
    logic [31:0] key;
    logic [7:0]  data;
    logic        frame_end;
  } job_t;

  // Queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Pick mask byte by position, first-sent byte at the top
  function automatic logic [7:0] mask_byte(input logic [31:0] key, input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

  // Position of the first mask byte in the header
  function automatic logic [3:0] mask_base(input len_fmt_e fmt);
    logic [3:0] base;
    case (fmt)
      LEN_SHORT:  base = 4'd2;
      LEN_MEDIUM: base = 4'd4;
      default:    base = 4'd10;
    endcase
    return base;
  endfunction

  // Byte of the header at a given index
  function automatic logic [7:0] header_byte(input len_fmt_e fmt, input logic [3:0] idx,
                                             input logic [31:0] len, input logic [31:0] key);
    logic [3:0] base;
    logic [3:0] off;
    logic [7:0] b;
    base = mask_base(fmt);
    off  = idx - base;
    b    = 8'h00;
    if (idx == 4'd0) begin
      b = OPCODE_BYTE;
    end else if (idx >= base) begin
      b = mask_byte(key, off[1:0]);
    end else begin
      case (fmt)
        LEN_SHORT: begin
          b = {1'b1, len[6:0]};
        end
        LEN_MEDIUM: begin
          case (idx)
            4'd1:    b = LEN16_MARK;
            4'd2:    b = len[15:8];
            default: b = len[7:0];
          endcase
        end
        default: begin
          case (idx)
            4'd1:    b = LEN64_MARK;
            4'd6:    b = len[31:24];
            4'd7:    b = len[23:16];
            4'd8:    b = len[15:8];
            4'd9:    b = len[7:0];
            default: b = 8'h00;
          endcase
        end
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

>>> hdl/websocket_masked_frame_encoder.sv
// ---------------------------------------------------------------------------
// websocket_masked_frame_encoder
// Client frame encoder: header, length field, mask key and masked payload.
// ---------------------------------------------------------------------------
//  channel  | handshake    | fields
//  ---------+--------------+----------------------------------------------
//  request  | push / full  | cmd_i payload_length_i mask_key_i payload_byte_i
//  result   | empty / pop  | out_byte_o last_of_run_o frame_end_o error_o
//
// A request is taken every cycle while the job queue has room. The serialiser
// sends one byte per cycle while the result is popped: a start request gives
// 6, 8 or 14 header bytes, a payload or error request one. The first result
// passes through the job queue and then the result register. Reset clears the
// frame state, the queue pointers and the result valid flag at once. A stalled
// result holds the serialiser; the queue then fills and raises full.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module websocket_masked_frame_encoder #(
  parameter int unsigned QueueDepth = wsfe_pkg::QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        cmd_i,
  input  wire logic [31:0] payload_length_i,
  input  wire logic [31:0] mask_key_i,
  input  wire logic [7:0]  payload_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o,
  output logic             frame_end_o,
  output logic             error_o
);
  import wsfe_pkg::*;

  job_t    job_in, job_head;
  q_stat_t q_stat;
  logic    job_push, job_pop;
  logic    err_fields_ok;

  assign full = q_stat.full;

  wsfe_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .q_full_i         (q_stat.full),
    .cmd_i            (cmd_i),
    .payload_length_i (payload_length_i),
    .mask_key_i       (mask_key_i),
    .payload_byte_i   (payload_byte_i),
    .job_push_o       (job_push),
    .job_o            (job_in)
  );

  wsfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .pop_i   (job_pop),
    .rdata_o (job_head),
    .stat_o  (q_stat)
  );

  wsfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job_head),
    .job_valid_i   (!q_stat.empty),
    .job_pop_o     (job_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .frame_end_o   (frame_end_o),
    .error_o       (error_o)
  );

  // Shape of an error result
  assign err_fields_ok = (out_byte_o == 8'h00) && !frame_end_o && last_of_run_o;

  // Checks on queue hand-off and result fields
  `ASSERT_IMPL(a_pop_not_empty, clk_i, rst_ni, job_pop, !q_stat.empty)
  `ASSERT_CLK(a_push_queued, clk_i, rst_ni, job_push |=> !q_stat.empty)
  `ASSERT_IMPL(a_err_fields, clk_i, rst_ni, !empty && error_o, err_fields_ok)
  `ASSERT_IMPL(a_end_is_last, clk_i, rst_ni, !empty && frame_end_o, last_of_run_o)

endmodule

`default_nettype wire

>>> hdl/wsfe_front.sv
// ---------------------------------------------------------------------------
// wsfe_front
// Accept requests, track the open frame and turn each request into a job.
// ---------------------------------------------------------------------------
`default_nettype none

module wsfe_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic          q_full_i,
  input  wire logic          cmd_i,
  input  wire logic [31:0]   payload_length_i,
  input  wire logic [31:0]   mask_key_i,
  input  wire logic [7:0]    payload_byte_i,
  output logic               job_push_o,
  output wsfe_pkg::job_t     job_o
);
  import wsfe_pkg::*;

  logic [31:0] bytes_left_q, bytes_left_d;
  logic [31:0] held_mask_q, held_mask_d;
  logic [1:0]  mask_pos_q, mask_pos_d;
  logic        frame_open_q, frame_open_d;
  logic        accept;
  logic        last_byte;

  assign accept    = push_i && !q_full_i;
  assign last_byte = (bytes_left_q == 32'd1);
  assign job_push_o = accept;

  // Classify the request and update the frame state
  always_comb begin
    bytes_left_d = bytes_left_q;
    held_mask_d  = held_mask_q;
    mask_pos_d   = mask_pos_q;
    frame_open_d = frame_open_q;

    job_o.kind      = JOB_ERROR;
    job_o.fmt       = LEN_SHORT;
    job_o.len       = payload_length_i;
    job_o.key       = mask_key_i;
    job_o.data      = 8'h00;
    job_o.frame_end = 1'b0;

    if (payload_length_i <= SHORT_LIMIT) begin
      job_o.fmt = LEN_SHORT;
    end else if (payload_length_i <= MEDIUM_LIMIT) begin
      job_o.fmt = LEN_MEDIUM;
    end else begin
      job_o.fmt = LEN_LONG;
    end

    if (!cmd_i) begin
      job_o.kind      = JOB_HEADER;
      job_o.frame_end = (payload_length_i == 32'd0);
    end else if (frame_open_q) begin
      job_o.kind      = JOB_DATA;
      job_o.data      = payload_byte_i ^ mask_byte(held_mask_q, mask_pos_q);
      job_o.frame_end = last_byte;
    end

    if (accept) begin
      if (!cmd_i) begin
        // Start a new frame, abandoning any open one
        bytes_left_d = payload_length_i;
        held_mask_d  = mask_key_i;
        mask_pos_d   = 2'd0;
        frame_open_d = (payload_length_i != 32'd0);
      end else if (frame_open_q) begin
        // Advance through the payload
        bytes_left_d = bytes_left_q - 32'd1;
        mask_pos_d   = mask_pos_q + 2'd1;
        frame_open_d = !last_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      held_mask_q  <= '0;
      mask_pos_q   <= '0;
      frame_open_q <= 1'b0;
    end else begin
      bytes_left_q <= bytes_left_d;
      held_mask_q  <= held_mask_d;
      mask_pos_q   <= mask_pos_d;
      frame_open_q <= frame_open_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/wsfe_queue.sv
// ---------------------------------------------------------------------------
// wsfe_queue
// Short job queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module wsfe_queue #(
  parameter int unsigned Depth = wsfe_pkg::QueueDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire wsfe_pkg::job_t wdata_i,
  input  wire logic          pop_i,
  output wsfe_pkg::job_t     rdata_o,
  output wsfe_pkg::q_stat_t  stat_o
);
  import wsfe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign rdata_o      = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming job
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/wsfe_back.sv
// ---------------------------------------------------------------------------
// wsfe_back
// Serialise jobs as bytes in the result register, one per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module wsfe_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire wsfe_pkg::job_t job_i,
  input  wire logic        job_valid_i,
  output logic             job_pop_o,
  input  wire logic        pop_i,
  output logic             empty_o,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o,
  output logic             frame_end_o,
  output logic             error_o
);
  import wsfe_pkg::*;

  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q;
  logic       last_q, fend_q, err_q;
  logic [3:0] idx_q, idx_d;
  logic       adv, take, job_done, hdr_last;
  logic [7:0] byte_c;
  logic       last_c, fend_c, err_c;

  assign adv      = !out_valid_q || pop_i;
  assign take     = adv && job_valid_i;
  assign hdr_last = (idx_q == mask_base(job_i.fmt) + 4'd3);

  // Produce the next byte of the head job
  always_comb begin
    byte_c   = 8'h00;
    last_c   = 1'b1;
    fend_c   = 1'b0;
    err_c    = 1'b0;
    job_done = 1'b1;
    case (job_i.kind)
      JOB_HEADER: begin
        byte_c   = header_byte(job_i.fmt, idx_q, job_i.len, job_i.key);
        last_c   = hdr_last;
        fend_c   = hdr_last && job_i.frame_end;
        job_done = hdr_last;
      end
      JOB_DATA: begin
        byte_c = job_i.data;
        fend_c = job_i.frame_end;
      end
      default: begin
        err_c = 1'b1;
      end
    endcase
  end

  assign job_pop_o = take && job_done;

  // Step the header index and the result register valid
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (take) begin
      idx_d = job_done ? 4'd0 : idx_q + 4'd1;
    end
    if (adv) begin
      out_valid_d = take;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= byte_c;
      last_q <= last_c;
      fend_q <= fend_c;
      err_q  <= err_c;
    end
  end

  assign empty_o       = !out_valid_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;
  assign frame_end_o   = fend_q;
  assign error_o       = err_q;

endmodule

`default_nettype wire

>>> test/wsfe_frame_checker.sv
// ---------------------------------------------------------------------------
// wsfe_frame_checker
// Watches the request and result channels of the frame encoder, predicts
// every wire byte from its own copy of the frame state and compares each
// popped byte field by field with the oldest predicted one.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

package wsfe_tb_pkg;

  // Request kinds on the cmd field
  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_PAYLOAD = 1'b1
  } frame_cmd_e;

endpackage

module wsfe_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic        cmd_i,
  input  logic [31:0] payload_length_i,
  input  logic [31:0] mask_key_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [7:0]  out_byte_i,
  input  logic        last_of_run_i,
  input  logic        frame_end_i,
  input  logic        error_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned frames_o,
  output int unsigned masked_bytes_o,
  output int unsigned strays_o,
  output int unsigned checked_o
);
  import wsfe_pkg::*;
  import wsfe_tb_pkg::*;

  localparam logic [7:0] MASK_FLAG = 8'h80;
  localparam int unsigned PRINT_CAP = 30;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_end;
    logic       error;
  } wire_byte_t;

  // Wire bytes still owed by the encoder, oldest first
  wire_byte_t wire_bytes_due[$];

  // Own copy of the frame state
  logic [31:0] bytes_left;
  logic [31:0] held_mask;
  logic [1:0]  mask_pos;
  logic        frame_open;

  int unsigned fail_total;
  int unsigned frame_total;
  int unsigned masked_total;
  int unsigned stray_total;
  int unsigned checked_total;

  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
    logic [31:0] shifted;
    shifted = key >> (24 - 8 * int'(pos));
    return shifted[7:0];
  endfunction

  task automatic owe_byte(input logic [7:0] b, input logic fe, input logic err);
    wire_byte_t wb;
    wb.out_byte    = b;
    wb.last_of_run = 1'b0;
    wb.frame_end   = fe;
    wb.error       = err;
    wire_bytes_due.push_back(wb);
  endtask

  // Work out the wire bytes of one request and advance the frame state
  task automatic encode_request(input logic cmd, input logic [31:0] len,
                                input logic [31:0] key, input logic [7:0] data);
    logic [7:0] masked;
    logic       closes;
    int         tail;
    wire_byte_t wb;
    if (cmd == CMD_START) begin
      frame_total++;
      owe_byte(OPCODE_BYTE, 1'b0, 1'b0);
      if (len <= SHORT_LIMIT) begin
        owe_byte(len[7:0] | MASK_FLAG, 1'b0, 1'b0);
      end else if (len <= MEDIUM_LIMIT) begin
        owe_byte(LEN16_MARK, 1'b0, 1'b0);
        owe_byte(len[15:8], 1'b0, 1'b0);
        owe_byte(len[7:0], 1'b0, 1'b0);
      end else begin
        owe_byte(LEN64_MARK, 1'b0, 1'b0);
        for (int i = 0; i < 4; i++) owe_byte(8'h00, 1'b0, 1'b0);
        for (int i = 0; i < 4; i++) owe_byte(key_byte(len, 2'(i)), 1'b0, 1'b0);
      end
      for (int i = 0; i < 4; i++) begin
        owe_byte(key_byte(key, 2'(i)), (i == 3) && (len == 32'd0), 1'b0);
      end
      held_mask  = key;
      mask_pos   = 2'd0;
      bytes_left = len;
      frame_open = (len != 32'd0);
    end else if (!frame_open) begin
      stray_total++;
      owe_byte(8'h00, 1'b0, 1'b1);
    end else begin
      masked_total++;
      masked     = data ^ key_byte(held_mask, mask_pos);
      mask_pos   = mask_pos + 2'd1;
      bytes_left = bytes_left - 32'd1;
      closes     = (bytes_left == 32'd0);
      if (closes) frame_open = 1'b0;
      owe_byte(masked, closes, 1'b0);
    end
    // Mark the final byte of this request
    tail = wire_bytes_due.size() - 1;
    wb = wire_bytes_due[tail];
    wb.last_of_run = 1'b1;
    wire_bytes_due[tail] = wb;
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (fail_total < PRINT_CAP) begin
      $display("%0t: mismatch on %s: got %02h, expected %02h (byte %0d)",
               $realtime, what, got, want, checked_total);
    end
    fail_total++;
  endtask

  // Predict on accepted requests, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    wire_byte_t want;
    if (!rst_ni) begin
      wire_bytes_due.delete();
      bytes_left    = '0;
      held_mask     = '0;
      mask_pos      = '0;
      frame_open    = 1'b0;
      fail_total    = 0;
      frame_total   = 0;
      masked_total  = 0;
      stray_total   = 0;
      checked_total = 0;
    end else begin
      if (push_i && !full_i) begin
        encode_request(cmd_i, payload_length_i, mask_key_i, payload_byte_i);
      end
      if (pop_i && !empty_i) begin
        if (wire_bytes_due.size() == 0) begin
          report_mismatch("unexpected byte", out_byte_i, 8'h00);
        end else begin
          want = wire_bytes_due.pop_front();
          if (out_byte_i !== want.out_byte)
            report_mismatch("out_byte", out_byte_i, want.out_byte);
          if (last_of_run_i !== want.last_of_run)
            report_mismatch("last_of_run", 8'(last_of_run_i), 8'(want.last_of_run));
          if (frame_end_i !== want.frame_end)
            report_mismatch("frame_end", 8'(frame_end_i), 8'(want.frame_end));
          if (error_i !== want.error)
            report_mismatch("error", 8'(error_i), 8'(want.error));
        end
        checked_total++;
      end
    end
    fail_count_o   <= fail_total;
    pending_o      <= wire_bytes_due.size();
    frames_o       <= frame_total;
    masked_bytes_o <= masked_total;
    strays_o       <= stray_total;
    checked_o      <= checked_total;
  end

endmodule

>>> test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives start and payload requests into the frame encoder with random
// gaps and result stalls: a directed set of length-format edges and stray
// bytes, then random frames, abandoned frames and noise. The checker beside
// the block predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import wsfe_pkg::*;
  import wsfe_tb_pkg::*;

  localparam int unsigned ITEM_TARGET   = 270;
  localparam int unsigned QUIET_TAIL    = 230;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 20;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        push             = 1'b0;
  logic        cmd_i            = 1'b0;
  logic [31:0] payload_length_i = '0;
  logic [31:0] mask_key_i       = '0;
  logic [7:0]  payload_byte_i   = '0;
  logic        pop              = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  out_byte_o;
  logic        last_of_run_o;
  logic        frame_end_o;
  logic        error_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned frames;
  int unsigned masked_bytes;
  int unsigned strays;
  int unsigned checked;

  int unsigned requests_sent = 0;
  int unsigned idle_cycles   = 0;
  int unsigned pop_hold      = 0;
  logic        sender_gaps   = 1'b0;
  logic        receiver_gaps = 1'b0;

  websocket_masked_frame_encoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .cmd_i           (cmd_i),
    .payload_length_i(payload_length_i),
    .mask_key_i      (mask_key_i),
    .payload_byte_i  (payload_byte_i),
    .empty           (empty),
    .pop             (pop),
    .out_byte_o      (out_byte_o),
    .last_of_run_o   (last_of_run_o),
    .frame_end_o     (frame_end_o),
    .error_o         (error_o)
  );

  wsfe_frame_checker frame_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_i          (full),
    .cmd_i           (cmd_i),
    .payload_length_i(payload_length_i),
    .mask_key_i      (mask_key_i),
    .payload_byte_i  (payload_byte_i),
    .empty_i         (empty),
    .pop_i           (pop),
    .out_byte_i      (out_byte_o),
    .last_of_run_i   (last_of_run_o),
    .frame_end_i     (frame_end_o),
    .error_i         (error_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .frames_o        (frames),
    .masked_bytes_o  (masked_bytes),
    .strays_o        (strays),
    .checked_o       (checked)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Pop side: stall in short random bursts while gaps are enabled
  always @(posedge clk_i) begin
    if (pop_hold > 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
      pop      <= 1'b0;
      pop_hold <= $urandom_range(0, 2);
    end else begin
      pop <= 1'b1;
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d bytes owed", idle_cycles, pending);
        $display("websocket_masked_frame_encoder verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Hold one request until it is taken, with an optional gap before it
  task automatic send_request(input logic c, input logic [31:0] len,
                              input logic [31:0] key, input logic [7:0] data);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push             <= 1'b1;
    cmd_i            <= c;
    payload_length_i <= len;
    mask_key_i       <= key;
    payload_byte_i   <= data;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic send_start(input logic [31:0] len, input logic [31:0] key);
    send_request(CMD_START, len, key, 8'($urandom));
  endtask

  task automatic send_payload(input logic [7:0] data);
    send_request(CMD_PAYLOAD, $urandom, $urandom, data);
  endtask

  task automatic send_random_payload(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_payload(8'($urandom));
  endtask

  // Stop sending until every owed byte has been popped
  task automatic drain;
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Pick gap behaviour for the next stretch of traffic
  task automatic pick_gaps;
    logic quiet;
    quiet = (requests_sent >= QUIET_TAIL);
    sender_gaps   <= !quiet && ($urandom_range(0, 2) != 0);
    receiver_gaps <= !quiet && ($urandom_range(0, 2) != 0);
  endtask

  initial begin
    int unsigned kind;
    logic [31:0] len;
    logic        drained_mid;
    drained_mid = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: stray bytes, length-format boundaries, abandon, wrap of the mask
    pick_gaps();
    send_payload(8'hFF);
    send_start(32'd0, 32'hFFFF_FFFF);
    send_payload(8'h00);
    send_start(32'd125, 32'h0000_0000);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_start(32'd126, 32'hA55A_3CC3);
    send_payload(8'hFF);
    pick_gaps();
    send_start(32'd65535, 32'h1234_5678);
    send_payload(8'h00);
    send_start(32'd65536, 32'h8765_4321);
    send_payload(8'h5A);
    send_start(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_payload(8'hFF);
    pick_gaps();
    send_start(32'd1, 32'h0000_0000);
    send_payload(8'h80);
    send_payload(8'h7F);
    send_start(32'd5, 32'hDEAD_BEEF);
    send_random_payload(5);
    drain();

    // Random: mostly complete short frames, some open or abandoned frames, some noise
    while (requests_sent < ITEM_TARGET) begin
      pick_gaps();
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        len = $urandom_range(0, 10);
        send_start(len, $urandom);
        if ($urandom_range(0, 7) == 0 && len > 1) begin
          send_random_payload($urandom_range(1, len - 1));
        end else begin
          send_random_payload(len);
        end
      end else if (kind == 6) begin
        send_start($urandom_range(126, 65535), $urandom);
        send_random_payload($urandom_range(0, 6));
      end else if (kind == 7) begin
        len = $urandom;
        if (len <= MEDIUM_LIMIT) len = len + 32'h0001_0000;
        send_start(len, $urandom);
        send_random_payload($urandom_range(0, 6));
      end else if (kind == 8) begin
        send_random_payload($urandom_range(1, 2));
      end else begin
        send_start($urandom, $urandom);
        send_random_payload($urandom_range(0, 4));
      end
      if (!drained_mid && requests_sent >= ITEM_TARGET / 2) begin
        drained_mid = 1'b1;
        drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("sent %0d requests: %0d frame starts, %0d payload bytes masked, %0d stray bytes",
             requests_sent, frames, masked_bytes, strays);
    $display("checked %0d wire bytes across short, 16-bit and 64-bit length headers", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("websocket_masked_frame_encoder verification clean");
    end else begin
      $display("websocket_masked_frame_encoder verification failed");
    end
    $finish;
  end

endmodule

>>> websocket_masked_frame_encoder.f
+incdir+hdl
hdl/wsfe_pkg.sv
hdl/wsfe_front.sv
hdl/wsfe_queue.sv
hdl/wsfe_back.sv
hdl/websocket_masked_frame_encoder.sv
test/wsfe_frame_checker.sv
test/testbench.sv
